>>> rtl/core/lzw12_encoder_core_macros.svh
// assertion macros shared by the lzw12 encoder rtl
// each macro expects clk and rst to be visible in the instantiating module
`ifndef LZW12_ENCODER_CORE_MACROS_SVH
`define LZW12_ENCODER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LZW12_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LZW12_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lzw12_pkg.sv
// shared constants and types for the lzw12 encoder
// no dependencies
`timescale 1ns / 1ps

package lzw12_pkg;

  // input symbol width
  localparam int BYTE_BITS = 8;

  // reserved codes
  localparam int EOS_CODE   = 256;
  localparam int FIRST_FREE = 257;

  // operations of the shared subtract unit
  typedef enum logic [1:0] {
    OP_REDUCE  = 2'd0,  // hash minus slot count
    OP_STEP    = 2'd1,  // slot count minus index
    OP_ADVANCE = 2'd2   // index minus step, wrapped into the table
  } sub_op_t;

endpackage

>>> rtl/core/lzw12_sub_unit.sv
// shared subtract unit: hash reduction, probe step and probe advance
// depends on lzw12_pkg
`timescale 1ns / 1ps

module lzw12_sub_unit #(
  parameter int WIDTH   = 13,
  parameter int SLOT_W  = 13,
  parameter int MODULUS = 5021
) (
  input  lzw12_pkg::sub_op_t op,
  input  logic [WIDTH-1:0]   hash,
  input  logic [SLOT_W-1:0]  idx,
  input  logic [SLOT_W-1:0]  step,
  output logic [WIDTH-1:0]   result,
  output logic               neg
);

  localparam logic [WIDTH:0] MOD_EXT = (WIDTH+1)'(MODULUS);

  logic [WIDTH:0] opa;
  logic [WIDTH:0] opb;
  logic [WIDTH:0] diff;
  logic [WIDTH:0] wrapped;

  // operand selection
  always_comb begin
    case (op)
      lzw12_pkg::OP_REDUCE: begin
        opa = {1'b0, hash};
        opb = MOD_EXT;
      end
      lzw12_pkg::OP_STEP: begin
        opa = MOD_EXT;
        opb = (WIDTH+1)'(idx);
      end
      lzw12_pkg::OP_ADVANCE: begin
        opa = (WIDTH+1)'(idx);
        opb = (WIDTH+1)'(step);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // one subtract, wrap back into the table when the probe index underflows
  assign diff    = opa - opb;
  assign wrapped = diff + MOD_EXT;
  assign neg     = diff[WIDTH];

  always_comb begin
    if (op == lzw12_pkg::OP_ADVANCE && diff[WIDTH]) begin
      result = wrapped[WIDTH-1:0];
    end else begin
      result = diff[WIDTH-1:0];
    end
  end

endmodule

>>> rtl/core/lzw12_dict_ram.sv
// single-port-write, registered-read dictionary memory
// no dependencies
`timescale 1ns / 1ps

module lzw12_dict_ram #(
  parameter int DEPTH  = 5021,
  parameter int WIDTH  = 33,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lzw12_encoder_core.sv
// lzw encoder, one byte per input beat, fixed-width codes per output beat
// each byte after the first is hashed, reduced below the slot count and probed (one memory
// read per probe); a hit gives no code, a miss emits the prefix; a stream's last byte adds two more beats
// s_tready is high only while idle, so a new byte is taken only once the last one is through
// reset and each end-of-stream code start a clearing pass over every slot of
// the dictionary memory; s_tready stays low until it completes
`timescale 1ns / 1ps
`include "lzw12_encoder_core_macros.svh"

module lzw12_encoder_core #(
  parameter int HASH_SLOTS = 5021,
  parameter int CODE_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] data_byte
  input  logic                                s_tlast,  // final_byte
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((CODE_BITS+7)/8)*8-1:0]      m_tdata,  // code_word, zero padded
  output logic                                m_tlast   // last_code
);

  localparam int OUT_W  = ((CODE_BITS + 7) / 8) * 8;
  localparam int SLOT_W = $clog2(HASH_SLOTS);
  localparam int HW     = (CODE_BITS > SLOT_W) ? CODE_BITS : SLOT_W;
  localparam int BB     = lzw12_pkg::BYTE_BITS;
  localparam int ENT_W  = 1 + 2 * CODE_BITS + BB;

  localparam logic [CODE_BITS:0]   TOP_CODE  = (CODE_BITS+1)'((1 << CODE_BITS) - 1);
  localparam logic [CODE_BITS:0]   FREE_INIT = (CODE_BITS+1)'(lzw12_pkg::FIRST_FREE);
  localparam logic [CODE_BITS-1:0] EOS       = CODE_BITS'(lzw12_pkg::EOS_CODE);
  localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(HASH_SLOTS - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_CHK    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;
  localparam logic [2:0] S_EOS    = 3'd7;

  logic [2:0]           state;
  logic [SLOT_W-1:0]    clr_addr;
  logic                 started;
  logic [CODE_BITS-1:0] prefix;
  logic [CODE_BITS:0]   next_free;
  logic [BB-1:0]        cur_byte;
  logic                 fin;
  logic [HW-1:0]        hash;
  logic [SLOT_W-1:0]    idx;
  logic [SLOT_W-1:0]    step;
  logic [SLOT_W-1:0]    cnt;
  logic [CODE_BITS-1:0] out_code;

  lzw12_pkg::sub_op_t   sub_op;
  logic [HW-1:0]        sub_res;
  logic                 sub_neg;

  logic                 we;
  logic [SLOT_W-1:0]    waddr;
  logic [ENT_W-1:0]     wdata;
  logic [SLOT_W-1:0]    raddr;
  logic [ENT_W-1:0]     rdata;

  logic                 rd_used;
  logic [CODE_BITS-1:0] rd_code;
  logic [CODE_BITS-1:0] rd_parent;
  logic [BB-1:0]        rd_byte;
  logic                 rd_match;
  logic                 in_beat;
  logic                 out_free;
  logic                 add_entry;
  logic                 load_eos;
  logic [HW-1:0]        hash_init;

  // dictionary entry fields
  assign rd_used   = rdata[ENT_W-1];
  assign rd_code   = rdata[ENT_W-2 -: CODE_BITS];
  assign rd_parent = rdata[ENT_W-2-CODE_BITS -: CODE_BITS];
  assign rd_byte   = rdata[BB-1:0];
  assign rd_match  = rd_used && rd_parent == prefix && rd_byte == cur_byte;

  // handshake
  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = OUT_W'(out_code);
  assign load_eos = (state == S_EOS) && out_free;

  // start index of the probe: byte shifted up, xor prefix
  assign hash_init = HW'({s_tdata, {(CODE_BITS-BB){1'b0}}}) ^ HW'(prefix);

  // shared unit operation follows the sequencer
  always_comb begin
    case (state)
      S_REDUCE: sub_op = lzw12_pkg::OP_REDUCE;
      S_STEP:   sub_op = lzw12_pkg::OP_STEP;
      default:  sub_op = lzw12_pkg::OP_ADVANCE;
    endcase
  end

  lzw12_sub_unit #(
    .WIDTH   (HW),
    .SLOT_W  (SLOT_W),
    .MODULUS (HASH_SLOTS)
  ) u_sub (
    .op     (sub_op),
    .hash   (hash),
    .idx    (idx),
    .step   (step),
    .result (sub_res),
    .neg    (sub_neg)
  );

  // memory access: clearing pass or new entry on a miss
  assign add_entry = (state == S_CHK) && !rd_used && next_free <= TOP_CODE;
  assign we        = (state == S_CLEAR) || add_entry;
  assign waddr     = (state == S_CLEAR) ? clr_addr : idx;
  assign wdata     = (state == S_CLEAR) ? '0
                   : {1'b1, next_free[CODE_BITS-1:0], prefix, cur_byte};
  assign raddr     = (state == S_CHK) ? sub_res[SLOT_W-1:0] : idx;

  lzw12_dict_ram #(
    .DEPTH  (HASH_SLOTS),
    .WIDTH  (ENT_W),
    .ADDR_W (SLOT_W)
  ) u_dict (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      started   <= 1'b0;
      prefix    <= '0;
      next_free <= FREE_INIT;
      fin       <= 1'b0;
      cnt       <= '0;
    end else begin
      case (state)
        // sweep every slot back to unused
        S_CLEAR: begin
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        // take a byte
        S_IDLE: begin
          if (in_beat) begin
            cur_byte <= s_tdata;
            fin      <= s_tlast;
            if (!started) begin
              started <= 1'b1;
              prefix  <= CODE_BITS'(s_tdata);
              state   <= s_tlast ? S_FLUSH : S_IDLE;
            end else begin
              hash  <= hash_init;
              state <= S_REDUCE;
            end
          end
        end
        // bring the hash below the slot count
        S_REDUCE: begin
          if (sub_neg) begin
            idx   <= hash[SLOT_W-1:0];
            state <= S_STEP;
          end else begin
            hash <= sub_res;
          end
        end
        // probe stride, first read issued here
        S_STEP: begin
          step  <= (idx == '0) ? SLOT_W'(1) : sub_res[SLOT_W-1:0];
          cnt   <= '0;
          state <= S_CHK;
        end
        // compare the slot just read
        S_CHK: begin
          if (rd_match) begin
            prefix <= rd_code;
            state  <= fin ? S_FLUSH : S_IDLE;
          end else if (!rd_used) begin
            if (add_entry) begin
              next_free <= next_free + 1'b1;
            end
            state <= S_EMIT;
          end else if (cnt == LAST_SLOT) begin
            state <= S_EMIT;
          end else begin
            idx <= sub_res[SLOT_W-1:0];
            cnt <= cnt + 1'b1;
          end
        end
        // emit the prefix, restart the string at the byte
        S_EMIT: begin
          if (out_free) begin
            prefix <= CODE_BITS'(cur_byte);
            state  <= fin ? S_FLUSH : S_IDLE;
          end
        end
        // pending code of the stream
        S_FLUSH: begin
          if (out_free) begin
            state <= S_EOS;
          end
        end
        // end-of-stream code, then back to reset state
        S_EOS: begin
          if (out_free) begin
            state     <= S_CLEAR;
            clr_addr  <= '0;
            started   <= 1'b0;
            prefix    <= '0;
            next_free <= FREE_INIT;
            fin       <= 1'b0;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free && (state == S_EMIT || state == S_FLUSH || state == S_EOS)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == S_EOS) begin
        out_code <= EOS;
        m_tlast  <= 1'b1;
      end else if (state == S_EMIT || state == S_FLUSH) begin
        out_code <= prefix;
        m_tlast  <= 1'b0;
      end
    end
  end

  // checks
  `LZW12_ASSERT_IMP(a_free_in_range, 1'b1, next_free <= TOP_CODE + 1'b1, "code counter overran")
  `LZW12_ASSERT_IMP(a_write_on_miss, we && state != S_CLEAR, state == S_CHK && !rd_used,
                    "dictionary written outside a miss")
  `LZW12_ASSERT_IMP(a_last_is_eos, m_tvalid && m_tlast, out_code == EOS,
                    "last beat without end-of-stream code")
  `LZW12_ASSERT_NXT(a_eos_restarts, load_eos, state == S_CLEAR && !started,
                    "stream end did not restart clearing")

endmodule
